### hdl/rfe_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the reader command frame encoder.
package rfe_pkg;

    localparam int KIND_W      = 2;
    localparam int PAYLOAD_W   = 32;
    localparam int PAGE_W      = 8;
    localparam int SYMBOL_W    = 2;
    localparam int TIME_W      = 10;
    localparam int CRC_W       = 8;
    localparam int FRAME_W     = 37;
    localparam int LEN_W       = 6;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;

    localparam int RFE_QUEUE_DEPTH = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_UID_REQ = 2'd0,
        KIND_SELECT  = 2'd1,
        KIND_WR_PAGE = 2'd2,
        KIND_WR_DATA = 2'd3
    } kind_t;

    localparam logic [SYMBOL_W-1:0] SYM_ZERO = 2'd0;
    localparam logic [SYMBOL_W-1:0] SYM_ONE  = 2'd1;
    localparam logic [SYMBOL_W-1:0] SYM_EOF  = 2'd2;

    typedef enum logic [1:0] {
        REG_GAP     = 2'd0,
        REG_ZERO_ON = 2'd1,
        REG_ONE_ON  = 2'd2
    } cfg_reg_t;

    localparam logic [4:0] UID_REQ_CODE = 5'b11001;
    localparam logic [4:0] SELECT_CODE  = 5'b00000;
    localparam logic [3:0] WR_PAGE_CODE = 4'b1000;

    localparam logic [CRC_W-1:0] CRC_POLY = 8'h1D;
    localparam logic [CRC_W-1:0] CRC_INIT = 8'hFF;

    localparam logic [TIME_W-1:0] GAP_RESET     = 10'd64;
    localparam logic [TIME_W-1:0] ZERO_ON_RESET = 10'd96;
    localparam logic [TIME_W-1:0] ONE_ON_RESET  = 10'd160;

    // One classified command: frame bits left-aligned, their count, and
    // whether a CRC-8 follows them.
    typedef struct packed {
        logic [FRAME_W-1:0] bits;
        logic [LEN_W-1:0]   nbits;
        logic               has_crc;
    } frame_desc_t;

    typedef struct packed {
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] zero_on;
        logic [TIME_W-1:0] one_on;
    } timing_cfg_t;

endpackage

### hdl/rfe_if.sv
`timescale 1ns / 1ps
// Request channel interfaces for commands in and line symbols out.
interface rfe_cmd_if;
    import rfe_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [PAYLOAD_W-1:0] payload;
    logic [PAGE_W-1:0]    page_number;

    modport source (output valid, output kind, output payload, output page_number,
                    input ready);
    modport sink (input valid, input kind, input payload, input page_number,
                  output ready);
endinterface

interface rfe_sym_if;
    import rfe_pkg::*;
    logic                valid;
    logic                ready;
    logic [SYMBOL_W-1:0] symbol;
    logic [TIME_W-1:0]   off_time_us;
    logic [TIME_W-1:0]   on_time_us;
    logic                last;

    modport source (output valid, output symbol, output off_time_us, output on_time_us,
                    output last, input ready);
    modport sink (input valid, input symbol, input off_time_us, input on_time_us,
                  input last, output ready);
endinterface

### hdl/rfid_reader_frame_encoder.sv
`timescale 1ns / 1ps
// Top level of the reader command frame encoder.
//
// Each command request on cmd expands into a frame of line symbols on sym,
// most significant bit first: a UID request sends 11001 (5 bits, no CRC), a
// select sends 00000 and the 32-bit UID, a write-page header sends 1000 and
// the 8-bit page, and write data sends the 32-bit word; all but the UID
// request are followed by a CRC-8 (polynomial 0x1D, init 0xFF, not
// reflected) over the bits before it. Every bit symbol reports the gap
// register as its off time and the zero or one on-time register as its on
// time; a closing end-of-frame symbol carries the gap, an on time of 0 and
// last set. The front end classifies a command in the cycle it is accepted
// and drops a descriptor into a short queue, so commands are taken while an
// earlier frame is still being sent. The back end sequencer sends one symbol
// per cycle while sym is not stalled and computes the CRC serially as the
// bits go out. The timing registers sit at byte addresses 0 (gap), 4 (zero
// on time) and 8 (one on time) of the APB port, reset to 64, 96 and 160, and
// are sampled as each symbol is formed, so write them only while the block
// is idle.
module rfid_reader_frame_encoder #(
    parameter int QUEUE_DEPTH = rfe_pkg::RFE_QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rfe_cmd_if.sink                         cmd,
    rfe_sym_if.source                       sym,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rfe_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [rfe_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [rfe_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import rfe_pkg::*;

    timing_cfg_t timing;
    frame_desc_t wr_desc;
    frame_desc_t rd_desc;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;

    rfe_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .timing  (timing)
    );

    // Front end: classify the command and build its frame descriptor.
    rfe_front u_front (
        .cmd  (cmd),
        .full (full),
        .push (push),
        .desc (wr_desc)
    );

    rfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_desc (wr_desc),
        .pop     (pop),
        .rd_desc (rd_desc),
        .full    (full),
        .empty   (empty)
    );

    // Back end: serialize the frame, append the CRC if it has one and close the frame.
    rfe_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .head   (rd_desc),
        .pop    (pop),
        .timing (timing),
        .sym    (sym)
    );

endmodule

### hdl/rfe_cfg.sv
`timescale 1ns / 1ps
// APB-style register file holding the three symbol timing registers.
module rfe_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rfe_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [rfe_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [rfe_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output rfe_pkg::timing_cfg_t            timing
);
    import rfe_pkg::*;

    logic [TIME_W-1:0] gap_reg;
    logic [TIME_W-1:0] zero_on_reg;
    logic [TIME_W-1:0] one_on_reg;
    logic              wr_en;
    cfg_reg_t          sel;
    logic [TIME_W-1:0] rd_val;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel    = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg     <= GAP_RESET;
            zero_on_reg <= ZERO_ON_RESET;
            one_on_reg  <= ONE_ON_RESET;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_GAP:     gap_reg     <= pwdata[TIME_W-1:0];
                REG_ZERO_ON: zero_on_reg <= pwdata[TIME_W-1:0];
                REG_ONE_ON:  one_on_reg  <= pwdata[TIME_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_GAP:     rd_val = gap_reg;
            REG_ZERO_ON: rd_val = zero_on_reg;
            REG_ONE_ON:  rd_val = one_on_reg;
            default:     rd_val = '0;
        endcase
    end

    assign prdata = {{(CFG_DATA_W-TIME_W){1'b0}}, rd_val};

    assign timing.gap     = gap_reg;
    assign timing.zero_on = zero_on_reg;
    assign timing.one_on  = one_on_reg;

endmodule

### hdl/rfe_front.sv
`timescale 1ns / 1ps
// Command front end: accepts a command and turns it into a frame descriptor.
module rfe_front (
    rfe_cmd_if.sink               cmd,
    input  logic                  full,
    output logic                  push,
    output rfe_pkg::frame_desc_t  desc
);
    import rfe_pkg::*;

    kind_t kind;

    assign kind      = kind_t'(cmd.kind);
    assign cmd.ready = !full;
    assign push      = cmd.valid && !full;

    // Frame bits are left-aligned so the back end always sends from the top.
    always_comb
    begin
        case (kind)
            KIND_UID_REQ:
            begin
                desc.bits    = {UID_REQ_CODE, {(FRAME_W-5){1'b0}}};
                desc.nbits   = LEN_W'(5);
                desc.has_crc = 1'b0;
            end
            KIND_SELECT:
            begin
                desc.bits    = {SELECT_CODE, cmd.payload};
                desc.nbits   = LEN_W'(FRAME_W);
                desc.has_crc = 1'b1;
            end
            KIND_WR_PAGE:
            begin
                desc.bits    = {WR_PAGE_CODE, cmd.page_number,
                                {(FRAME_W-4-PAGE_W){1'b0}}};
                desc.nbits   = LEN_W'(4 + PAGE_W);
                desc.has_crc = 1'b1;
            end
            default:
            begin
                desc.bits    = {cmd.payload, {(FRAME_W-PAYLOAD_W){1'b0}}};
                desc.nbits   = LEN_W'(PAYLOAD_W);
                desc.has_crc = 1'b1;
            end
        endcase
    end

endmodule

### hdl/rfe_queue.sv
`timescale 1ns / 1ps
// Small descriptor queue between the front and back ends.
module rfe_queue #(
    parameter int DEPTH = rfe_pkg::RFE_QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rfe_pkg::frame_desc_t  wr_desc,
    input  logic                  pop,
    output rfe_pkg::frame_desc_t  rd_desc,
    output logic                  full,
    output logic                  empty
);
    import rfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_desc_t       entries [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_desc = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= wr_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### hdl/rfe_back.sv
`timescale 1ns / 1ps
// Symbol sequencer: sends frame bits, the CRC-8 if any, then the closing gap.
module rfe_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  empty,
    input  rfe_pkg::frame_desc_t  head,
    output logic                  pop,
    input  rfe_pkg::timing_cfg_t  timing,
    rfe_sym_if.source             sym
);
    import rfe_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DATA,
        ST_CRC,
        ST_EOF
    } state_t;

    state_t              state_reg,   state_next;
    logic [FRAME_W-1:0]  shift_reg,   shift_next;
    logic [LEN_W-1:0]    cnt_reg,     cnt_next;
    logic [CRC_W-1:0]    crc_reg,     crc_next;
    logic                has_crc_reg, has_crc_next;
    logic                valid_reg,   valid_next;
    logic [SYMBOL_W-1:0] symbol_reg,  symbol_next;
    logic [TIME_W-1:0]   off_reg,     off_next;
    logic [TIME_W-1:0]   on_reg,      on_next;
    logic                last_reg,    last_next;
    logic                out_free;
    logic                bit_val;

    assign out_free = !valid_reg || sym.ready;
    assign pop      = (state_reg == ST_IDLE) && !empty;

    always_comb
    begin
        state_next   = state_reg;
        shift_next   = shift_reg;
        cnt_next     = cnt_reg;
        crc_next     = crc_reg;
        has_crc_next = has_crc_reg;
        valid_next   = valid_reg && !sym.ready;
        symbol_next  = symbol_reg;
        off_next     = off_reg;
        on_next      = on_reg;
        last_next    = last_reg;
        bit_val      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    shift_next   = head.bits;
                    cnt_next     = head.nbits;
                    has_crc_next = head.has_crc;
                    crc_next     = CRC_INIT;
                    state_next   = ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (out_free)
                begin
                    bit_val    = shift_reg[FRAME_W-1];
                    shift_next = {shift_reg[FRAME_W-2:0], 1'b0};
                    crc_next   = {crc_reg[CRC_W-2:0], 1'b0}
                               ^ ((crc_reg[CRC_W-1] ^ bit_val) ? CRC_POLY : '0);
                    cnt_next   = cnt_reg - 1'b1;
                    if (cnt_reg == LEN_W'(1))
                    begin
                        cnt_next   = LEN_W'(CRC_W);
                        state_next = has_crc_reg ? ST_CRC : ST_EOF;
                    end
                end
            end
            ST_CRC:
            begin
                if (out_free)
                begin
                    bit_val  = crc_reg[CRC_W-1];
                    crc_next = {crc_reg[CRC_W-2:0], 1'b0};
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == LEN_W'(1))
                        state_next = ST_EOF;
                end
            end
            ST_EOF:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_free && (state_reg == ST_DATA || state_reg == ST_CRC))
        begin
            valid_next  = 1'b1;
            symbol_next = bit_val ? SYM_ONE : SYM_ZERO;
            off_next    = timing.gap;
            on_next     = bit_val ? timing.one_on : timing.zero_on;
            last_next   = 1'b0;
        end
        else if (out_free && state_reg == ST_EOF)
        begin
            valid_next  = 1'b1;
            symbol_next = SYM_EOF;
            off_next    = timing.gap;
            on_next     = '0;
            last_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            shift_reg   <= '0;
            cnt_reg     <= '0;
            crc_reg     <= CRC_INIT;
            has_crc_reg <= 1'b0;
            valid_reg   <= 1'b0;
            symbol_reg  <= SYM_ZERO;
            off_reg     <= '0;
            on_reg      <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            shift_reg   <= shift_next;
            cnt_reg     <= cnt_next;
            crc_reg     <= crc_next;
            has_crc_reg <= has_crc_next;
            valid_reg   <= valid_next;
            symbol_reg  <= symbol_next;
            off_reg     <= off_next;
            on_reg      <= on_next;
            last_reg    <= last_next;
        end
    end

    assign sym.valid       = valid_reg;
    assign sym.symbol      = symbol_reg;
    assign sym.off_time_us = off_reg;
    assign sym.on_time_us  = on_reg;
    assign sym.last        = last_reg;

endmodule

### hdl/rfe_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the frame encoder and their binding to the top level.
module rfe_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           sym_valid,
    input logic                           sym_ready,
    input logic [rfe_pkg::SYMBOL_W-1:0]   sym_symbol,
    input logic [rfe_pkg::TIME_W-1:0]     sym_off,
    input logic [rfe_pkg::TIME_W-1:0]     sym_on,
    input logic                           sym_last,
    input logic                           pready
);
    import rfe_pkg::*;

    // A stalled symbol request keeps its contents.
    a_sym_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && !sym_ready |=> sym_valid && $stable(sym_symbol)
            && $stable(sym_off) && $stable(sym_on) && $stable(sym_last))
        else $error("stalled symbol changed");

    // The closing symbol is the end-of-frame gap with an on time of zero.
    a_last_is_eof: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && sym_last |-> sym_symbol == SYM_EOF && sym_on == '0)
        else $error("last symbol is not an end-of-frame gap");

    // Bit symbols never carry last, and no other code appears.
    a_bit_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && !sym_last |-> sym_symbol == SYM_ZERO || sym_symbol == SYM_ONE)
        else $error("bit symbol with bad code");

    // The register port never inserts wait states.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind rfid_reader_frame_encoder rfe_checker u_rfe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .sym_valid  (sym.valid),
    .sym_ready  (sym.ready),
    .sym_symbol (sym.symbol),
    .sym_off    (sym.off_time_us),
    .sym_on     (sym.on_time_us),
    .sym_last   (sym.last),
    .pready     (pready)
);
